// ===== src/int8_logit_softmax_unit_defines.svh =====
// ----------------------------------------------------------------------------
// int8 logit softmax assertion macros
// Shared assertion forms for the softmax unit checkers.
// ----------------------------------------------------------------------------
`ifndef INT8_LOGIT_SOFTMAX_UNIT_DEFINES_SVH
`define INT8_LOGIT_SOFTMAX_UNIT_DEFINES_SVH

// consequent must hold in the same cycle
`define ILS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("softmax unit check failed");

// consequent must hold in the next cycle
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("softmax unit check failed");

`endif

// ===== src/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Constants, types and the exponent table of the int8 logit softmax unit.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int CLASS_COUNT_DEF    = 8;
	localparam int PROB_FRAC_BITS_DEF = 16;
	localparam int LOGIT_W            = 8;
	localparam int PROB_W             = 16;
	localparam int EXP_W              = 5;
	localparam logic signed [EXP_W-1:0] EXP_MAX = 5'sd8;
	localparam int WEIGHT_W           = 17;
	localparam int PROD_W             = 25;
	localparam logic [WEIGHT_W-1:0] LOG2E_Q16 = 17'd94548;
	localparam int PROB_CAP           = 65535;

	// front pipeline and queue sizing
	localparam int FRONT_STAGES = 6;
	localparam int QUEUE_DEPTH  = 8;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// 2^(-j/64) table, Q1.16
	localparam int TAB_DEPTH = 64;
	typedef logic [WEIGHT_W-1:0] exp_tab_t [TAB_DEPTH];

	localparam logic [30:0] COARSE_Q30 [8] = '{
		31'd1073741824, 31'd984625594, 31'd902905651, 31'd827968132,
		31'd759250125, 31'd696235434, 31'd638450708, 31'd585461881
	};
	localparam logic [30:0] FINE_Q30 [8] = '{
		31'd1073741824, 31'd1062175491, 31'd1050733751, 31'd1039415260,
		31'd1028218693, 31'd1017142739, 31'd1006186087, 31'd995347463
	};

	function automatic exp_tab_t build_exp_table();
		exp_tab_t    tab;
		logic [63:0] prod;
		for (int j = 0; j < TAB_DEPTH; j++) begin
			prod = 64'(COARSE_Q30[j >> 3]) * 64'(FINE_Q30[j & 7]);
			prod = prod + (64'd1 << 43);
			tab[j] = WEIGHT_W'(prod >> 44);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TABLE = build_exp_table();

	// queue fill status seen by both sides
	typedef struct packed {
		logic [QUEUE_CNT_W-1:0] count;
		logic                   nonempty;
	} queue_status_t;

endpackage

// ===== src/ils_channels.sv =====
// ----------------------------------------------------------------------------
// ils channels
// Valid/ready channels for logit vectors and probability vectors.
// ----------------------------------------------------------------------------
interface ils_logit_if #(
	parameter int CLASS_COUNT = ils_pkg::CLASS_COUNT_DEF
);
	logic valid;
	logic ready;
	logic [CLASS_COUNT-1:0][ils_pkg::LOGIT_W-1:0] logit;

	modport source (output valid, output logit, input ready);
	modport sink (input valid, input logit, output ready);
endinterface

interface ils_prob_if #(
	parameter int CLASS_COUNT = ils_pkg::CLASS_COUNT_DEF
);
	logic valid;
	logic ready;
	logic [CLASS_COUNT-1:0][ils_pkg::PROB_W-1:0] prob;

	modport source (output valid, output prob, input ready);
	modport sink (input valid, input prob, output ready);
endinterface

// ===== src/ils_front.sv =====
// ----------------------------------------------------------------------------
// ils_front
// Max search, fixed-point exponent weights and their sum, six stages.
// ----------------------------------------------------------------------------
module ils_front #(
	parameter int CLASS_COUNT = ils_pkg::CLASS_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ils_pkg::EXP_W-1:0]     scale_exponent,
	ils_logit_if.sink                     logits,
	input  ils_pkg::queue_status_t        q_status,
	output logic                          push,
	output logic [CLASS_COUNT*ils_pkg::WEIGHT_W+ils_pkg::WEIGHT_W+$clog2(CLASS_COUNT)-1:0]
		push_data
);

	localparam int WW    = ils_pkg::WEIGHT_W;
	localparam int SUM_W = WW + $clog2(CLASS_COUNT);
	localparam int Y_W   = ils_pkg::PROD_W + 8;
	localparam int HALF  = CLASS_COUNT / 2;
	localparam int BUSY_W = ils_pkg::QUEUE_CNT_W + 1;

	logic [ils_pkg::FRONT_STAGES-1:0] stage_vld_q;
	logic [BUSY_W-1:0]                busy;
	logic                             accept;

	logic signed [7:0]               mx;
	logic signed [7:0]               logit_s1 [CLASS_COUNT];
	logic signed [7:0]               max_s1;
	logic [ils_pkg::PROD_W-1:0]      prod_s2 [CLASS_COUNT];
	logic signed [ils_pkg::EXP_W-1:0] e_clamp;
	logic [ils_pkg::EXP_W-1:0]       neg_shift;
	logic [Y_W-1:0]                  y [CLASS_COUNT];
	logic                            kbig_s3 [CLASS_COUNT];
	logic [4:0]                      k_s3 [CLASS_COUNT];
	logic [5:0]                      j_s3 [CLASS_COUNT];
	logic [WW-1:0]                   w_s4 [CLASS_COUNT];
	logic [WW-1:0]                   w_s5 [CLASS_COUNT];
	logic [WW-1:0]                   w_s6 [CLASS_COUNT];
	logic [SUM_W-1:0]                lo_sum, hi_sum;
	logic [SUM_W-1:0]                lo_s5, hi_s5;
	logic [SUM_W-1:0]                sum_s6;

	// credit: items in flight plus queued never exceed the queue depth
	always_comb begin
		busy = BUSY_W'(q_status.count);
		for (int s = 0; s < ils_pkg::FRONT_STAGES; s++) begin
			busy = busy + BUSY_W'(stage_vld_q[s]);
		end
	end

	assign logits.ready = (busy < BUSY_W'(ils_pkg::QUEUE_DEPTH));
	assign accept       = logits.valid && logits.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			stage_vld_q <= {stage_vld_q[ils_pkg::FRONT_STAGES-2:0], accept};
		end
	end

	// stage 1: largest logit
	always_comb begin
		mx = -8'sd128;
		for (int i = 0; i < CLASS_COUNT; i++) begin
			if ($signed(logits.logit[i]) > mx) begin
				mx = $signed(logits.logit[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CLASS_COUNT; i++) begin
			logit_s1[i] <= $signed(logits.logit[i]);
		end
		max_s1 <= mx;
	end

	// stage 2: difference times log2(e), difference is 0..255 unsigned
	always_ff @(posedge clk) begin
		for (int i = 0; i < CLASS_COUNT; i++) begin
			prod_s2[i] <= ils_pkg::PROD_W'($unsigned(8'(max_s1 - logit_s1[i])))
				* ils_pkg::PROD_W'(ils_pkg::LOG2E_Q16);
		end
	end

	// stage 3: apply scale, split integer and fraction
	always_comb begin
		e_clamp = ($signed(scale_exponent) > ils_pkg::EXP_MAX)
			? ils_pkg::EXP_MAX : $signed(scale_exponent);
		neg_shift = ils_pkg::EXP_W'(5'sd0 - e_clamp);
		for (int i = 0; i < CLASS_COUNT; i++) begin
			if (!e_clamp[ils_pkg::EXP_W-1]) begin
				y[i] = Y_W'(prod_s2[i]) << e_clamp[3:0];
			end else begin
				y[i] = Y_W'(prod_s2[i]) >> neg_shift;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CLASS_COUNT; i++) begin
			kbig_s3[i] <= (y[i][Y_W-1:16] > (Y_W-16)'(16));
			k_s3[i]    <= y[i][20:16];
			j_s3[i]    <= y[i][15:10];
		end
	end

	// stage 4: table lookup and integer shift
	always_ff @(posedge clk) begin
		for (int i = 0; i < CLASS_COUNT; i++) begin
			w_s4[i] <= kbig_s3[i] ? '0 : (ils_pkg::EXP_TABLE[j_s3[i]] >> k_s3[i]);
		end
	end

	// stage 5: half sums
	always_comb begin
		lo_sum = '0;
		hi_sum = '0;
		for (int i = 0; i < CLASS_COUNT; i++) begin
			if (i < HALF) begin
				lo_sum = lo_sum + SUM_W'(w_s4[i]);
			end else begin
				hi_sum = hi_sum + SUM_W'(w_s4[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_s5 <= lo_sum;
		hi_s5 <= hi_sum;
		w_s5  <= w_s4;
	end

	// stage 6: total
	always_ff @(posedge clk) begin
		sum_s6 <= lo_s5 + hi_s5;
		w_s6   <= w_s5;
	end

	always_comb begin
		push_data = '0;
		for (int i = 0; i < CLASS_COUNT; i++) begin
			push_data[i*WW +: WW] = w_s6[i];
		end
		push_data[CLASS_COUNT*WW +: SUM_W] = sum_s6;
	end

	assign push = stage_vld_q[ils_pkg::FRONT_STAGES-1];

endmodule

// ===== src/ils_queue.sv =====
// ----------------------------------------------------------------------------
// ils_queue
// Short first-in first-out queue between the weight front and divider back.
// ----------------------------------------------------------------------------
module ils_queue #(
	parameter int ENTRY_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [ENTRY_W-1:0]     push_data,
	input  logic                   pop,
	output logic [ENTRY_W-1:0]     pop_data,
	output ils_pkg::queue_status_t status
);

	localparam int PW = ils_pkg::QUEUE_PTR_W;
	localparam int CW = ils_pkg::QUEUE_CNT_W;

	logic [ENTRY_W-1:0] slot_q [ils_pkg::QUEUE_DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data        = slot_q[rd_ptr_q];
	assign status.count    = count_q;
	assign status.nonempty = (count_q != '0);

endmodule

// ===== src/ils_back.sv =====
// ----------------------------------------------------------------------------
// ils_back
// Pipelined restoring dividers, one quotient bit per stage, and output register.
// ----------------------------------------------------------------------------
module ils_back #(
	parameter int CLASS_COUNT    = ils_pkg::CLASS_COUNT_DEF,
	parameter int PROB_FRAC_BITS = ils_pkg::PROB_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ils_pkg::queue_status_t q_status,
	output logic                   pop,
	input  logic [CLASS_COUNT*ils_pkg::WEIGHT_W+ils_pkg::WEIGHT_W+$clog2(CLASS_COUNT)-1:0]
		pop_data,
	ils_prob_if.source             probs
);

	localparam int WW    = ils_pkg::WEIGHT_W;
	localparam int SUM_W = WW + $clog2(CLASS_COUNT);
	localparam int QB    = PROB_FRAC_BITS + 1;
	localparam int NW    = PROB_FRAC_BITS + 18;
	localparam int CAP   = ((1 << PROB_FRAC_BITS) - 1 > ils_pkg::PROB_CAP)
		? ils_pkg::PROB_CAP : (1 << PROB_FRAC_BITS) - 1;
	localparam int CMP_W = (QB > ils_pkg::PROB_W) ? QB : ils_pkg::PROB_W + 1;

	logic                 en;
	logic [QB:0]          vld_s;
	logic [SUM_W-1:0]     sum_s  [QB+1];
	logic [SUM_W-1:0]     rem_s  [QB+1][CLASS_COUNT];
	logic [QB-1:0]        bits_s [QB+1][CLASS_COUNT];
	logic [SUM_W-1:0]     rem_nxt  [QB][CLASS_COUNT];
	logic [QB-1:0]        bits_nxt [QB][CLASS_COUNT];
	logic [SUM_W:0]       trial;
	logic                 ge;
	logic [SUM_W-1:0]     in_sum;
	logic [NW-1:0]        num [CLASS_COUNT];
	logic                 out_vld_q;
	logic [CLASS_COUNT-1:0][ils_pkg::PROB_W-1:0] prob_q;

	// whole back end moves unless the output is held
	assign en  = !out_vld_q || probs.ready;
	assign pop = en && q_status.nonempty;

	// numerator with rounding half of the sum
	always_comb begin
		in_sum = pop_data[CLASS_COUNT*WW +: SUM_W];
		for (int i = 0; i < CLASS_COUNT; i++) begin
			num[i] = (NW'(pop_data[i*WW +: WW]) << PROB_FRAC_BITS) + NW'(in_sum >> 1);
		end
	end

	// one quotient bit per stage
	always_comb begin
		for (int s = 0; s < QB; s++) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				trial = {rem_s[s][i], bits_s[s][i][QB-1]};
				ge    = (trial >= {1'b0, sum_s[s]});
				rem_nxt[s][i]  = ge ? SUM_W'(trial - {1'b0, sum_s[s]}) : SUM_W'(trial);
				bits_nxt[s][i] = {bits_s[s][i][QB-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[QB-1:0], pop};
			out_vld_q <= vld_s[QB];
		end
	end

	// divider payload
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s[0] <= in_sum;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				rem_s[0][i]  <= SUM_W'(num[i] >> QB);
				bits_s[0][i] <= num[i][QB-1:0];
			end
			for (int s = 0; s < QB; s++) begin
				sum_s[s+1] <= sum_s[s];
				for (int i = 0; i < CLASS_COUNT; i++) begin
					rem_s[s+1][i]  <= rem_nxt[s][i];
					bits_s[s+1][i] <= bits_nxt[s][i];
				end
			end
		end
	end

	// saturate and register the result
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				prob_q[i] <= (CMP_W'(bits_s[QB][i]) > CMP_W'(CAP))
					? ils_pkg::PROB_W'(CAP) : ils_pkg::PROB_W'(bits_s[QB][i]);
			end
		end
	end

	assign probs.valid = out_vld_q;
	assign probs.prob  = prob_q;

endmodule

// ===== src/int8_logit_softmax_unit.sv =====
// ----------------------------------------------------------------------------
// int8_logit_softmax_unit
// Softmax over signed 8-bit logits with a power-of-two scale, Q0.16 output.
// ----------------------------------------------------------------------------
// channel   | dir | handshake    | payload
// logits    | in  | valid/ready  | logit[CLASS_COUNT], signed 8 bit
// probs     | out | valid/ready  | prob[CLASS_COUNT], unsigned 16 bit
// cfg       | in  | cfg_we       | cfg_wdata, scale_exponent, 5 bit signed
//
// one item per cycle sustained while the output is not stalled
// the path runs through the six-stage weight front and one divider stage per quotient bit
// arst_n clears all valid state and sets scale_exponent to zero
// the front takes items while its credit against the eight-entry queue allows
// an output stall freezes the divider pipeline; the front keeps filling the queue
// ----------------------------------------------------------------------------
module int8_logit_softmax_unit #(
	parameter int CLASS_COUNT    = ils_pkg::CLASS_COUNT_DEF,
	parameter int PROB_FRAC_BITS = ils_pkg::PROB_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ils_pkg::EXP_W-1:0] cfg_wdata,
	ils_logit_if.sink                 logits,
	ils_prob_if.source                probs
);

	localparam int ENTRY_W = CLASS_COUNT * ils_pkg::WEIGHT_W + ils_pkg::WEIGHT_W
		+ $clog2(CLASS_COUNT);

	logic [ils_pkg::EXP_W-1:0] scale_exponent_q;
	ils_pkg::queue_status_t    q_status;
	logic                      push, pop;
	logic [ENTRY_W-1:0]        push_data, pop_data;

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_exponent_q <= '0;
		end else if (cfg_we) begin
			scale_exponent_q <= cfg_wdata;
		end
	end

	ils_front #(
		.CLASS_COUNT (CLASS_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.scale_exponent (scale_exponent_q),
		.logits         (logits),
		.q_status       (q_status),
		.push           (push),
		.push_data      (push_data)
	);

	ils_queue #(
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	ils_back #(
		.CLASS_COUNT    (CLASS_COUNT),
		.PROB_FRAC_BITS (PROB_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop      (pop),
		.pop_data (pop_data),
		.probs    (probs)
	);

endmodule

// ===== src/ils_checker.sv =====
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the softmax unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "int8_logit_softmax_unit_defines.svh"

module ils_checker #(
	parameter int CLASS_COUNT    = ils_pkg::CLASS_COUNT_DEF,
	parameter int PROB_FRAC_BITS = ils_pkg::PROB_FRAC_BITS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [CLASS_COUNT*ils_pkg::PROB_W-1:0] out_prob
);

	localparam int BOUND = ils_pkg::QUEUE_DEPTH + PROB_FRAC_BITS + 3;

	logic [7:0] outstanding_q;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 8'(in_valid && in_ready)
				- 8'(out_valid && out_ready);
		end
	end

	`ILS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_prob))
	`ILS_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid && out_ready, outstanding_q != 8'd0)
	`ILS_ASSERT_NOW(a_bounded, clk, arst_n, 1'b1, outstanding_q <= 8'(BOUND))
	`ILS_ASSERT_NOW(a_idle_ready, clk, arst_n, outstanding_q == 8'd0, in_ready)

endmodule

bind int8_logit_softmax_unit ils_checker #(
	.CLASS_COUNT    (CLASS_COUNT),
	.PROB_FRAC_BITS (PROB_FRAC_BITS)
) u_ils_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (logits.valid),
	.in_ready  (logits.ready),
	.out_valid (probs.valid),
	.out_ready (probs.ready),
	.out_prob  (probs.prob)
);
